[rtl/iira_pkg.sv]
// shared types and codes for the indexed insert/remove list
package iira_pkg;

    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 2;
    localparam int DATA_BITS   = 32;

    typedef enum logic [OP_BITS-1:0] {
        OP_PUSH_BACK     = 3'd0,
        OP_POP_BACK      = 3'd1,
        OP_INSERT_AT     = 3'd2,
        OP_REMOVE_AT     = 3'd3,
        OP_INSERT_MIDDLE = 3'd4,
        OP_REMOVE_MIDDLE = 3'd5
    } op_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK     = 2'd0,
        ST_FULL   = 2'd1,
        ST_EMPTY  = 2'd2,
        ST_BADIDX = 2'd3
    } status_t;

    // per-cycle command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic rem;
        logic cap;
        logic shf;
    } cell_ctrl_t;

endpackage

[rtl/indexed_insert_remove_array.sv]
// top level of the indexed insert/remove list: control plus a row of cells
//
//  channel | dir | tdata fields (low bit up)                    | width @ defaults
//  s_      | in  | operation[3], position[CW], data_word[32]    | 40
//  m_      | out | status[2], taken_word[32], element_count[CW] | 40
//
// one item per cycle for inserts, appends, refused and unknown operations, while m_tready stays high
// a successful removal stalls new items in S_DRAIN: the taken word walks one cell a
// cycle down the taken-word chain to cell zero before the result is posted
// reset clears the count and control only; cell contents are left as they are
// the next item is taken while a result waits, provided m_tready is high
module indexed_insert_remove_array
    import iira_pkg::*;
#(
    parameter int CAPACITY  = 16,
    parameter int WORD_BITS = 32,
    localparam int CW  = $clog2(CAPACITY + 1),
    localparam int S_W = ((OP_BITS + CW + DATA_BITS + 7) / 8) * 8,
    localparam int M_W = ((STATUS_BITS + DATA_BITS + CW + 7) / 8) * 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [S_W-1:0] s_tdata,  // operation, position, data_word
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [M_W-1:0] m_tdata   // status, taken_word, element_count
);

    logic [OP_BITS-1:0]     operation;
    logic [CW-1:0]          position;
    logic [DATA_BITS-1:0]   data_word;
    logic [WORD_BITS-1:0]   new_word;

    logic [STATUS_BITS-1:0] status;
    logic [CW-1:0]          count;
    logic                   from_tk;
    cell_ctrl_t             cell_ctrl;
    logic [CW-1:0]          pos_eff;

    logic [WORD_BITS-1:0]   words [CAPACITY];
    logic [WORD_BITS-1:0]   tks   [CAPACITY];
    logic [DATA_BITS-1:0]   taken_word;

    assign operation = s_tdata[OP_BITS-1:0];
    assign position  = s_tdata[OP_BITS +: CW];
    assign data_word = s_tdata[OP_BITS + CW +: DATA_BITS];
    assign new_word  = WORD_BITS'(data_word);

    iira_ctrl #(
        .CAPACITY (CAPACITY),
        .CW       (CW)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .operation (operation),
        .position  (position),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .status    (status),
        .count     (count),
        .from_tk   (from_tk),
        .cell_ctrl (cell_ctrl),
        .pos_eff   (pos_eff)
    );

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic [WORD_BITS-1:0] left_w, right_w, right_t;
        if (i == 0) begin : g_first
            assign left_w = new_word;
        end else begin : g_mid
            assign left_w = words[i-1];
        end
        if (i == CAPACITY - 1) begin : g_last
            assign right_w = '0;
            assign right_t = '0;
        end else begin : g_inner
            assign right_w = words[i+1];
            assign right_t = tks[i+1];
        end
        iira_cell #(
            .WB  (WORD_BITS),
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .ctrl       (cell_ctrl),
            .pos        (pos_eff),
            .new_word   (new_word),
            .left_word  (left_w),
            .right_word (right_w),
            .right_tk   (right_t),
            .word       (words[i]),
            .tk         (tks[i])
        );
    end

    assign taken_word = from_tk ? DATA_BITS'(tks[0]) : '0;
    assign m_tdata    = M_W'({count, taken_word, status});

endmodule

[rtl/iira_cell.sv]
// one storage cell of the list with its share of the taken-word chain
module iira_cell
    import iira_pkg::*;
#(
    parameter int WB  = 32,
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  logic          aclk,
    input  cell_ctrl_t    ctrl,
    input  logic [CW-1:0] pos,
    input  logic [WB-1:0] new_word,
    input  logic [WB-1:0] left_word,
    input  logic [WB-1:0] right_word,
    input  logic [WB-1:0] right_tk,
    output logic [WB-1:0] word,
    output logic [WB-1:0] tk
);

    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [WB-1:0] word_reg, word_next;
    logic [WB-1:0] tk_reg, tk_next;

    always_comb begin
        word_next = word_reg;
        if (ctrl.ins) begin
            if (MY_IDX > pos) begin
                word_next = left_word;
            end else if (MY_IDX == pos) begin
                word_next = new_word;
            end
        end else if (ctrl.rem) begin
            if (MY_IDX >= pos) begin
                word_next = right_word;
            end
        end
    end

    // taken word walks toward cell zero one cell a cycle
    always_comb begin
        tk_next = tk_reg;
        if (ctrl.cap) begin
            tk_next = (MY_IDX == pos) ? word_reg : right_tk;
        end else if (ctrl.shf) begin
            tk_next = right_tk;
        end
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
        tk_reg   <= tk_next;
    end

    assign word = word_reg;
    assign tk   = tk_reg;

endmodule

[rtl/iira_ctrl.sv]
// operation decode, element count and handshake sequencing
module iira_ctrl
    import iira_pkg::*;
#(
    parameter int CAPACITY = 16,
    parameter int CW       = 5
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [OP_BITS-1:0]     operation,
    input  logic [CW-1:0]          position,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [STATUS_BITS-1:0] status,
    output logic [CW-1:0]          count,
    output logic                   from_tk,
    output cell_ctrl_t             cell_ctrl,
    output logic [CW-1:0]          pos_eff
);

    typedef enum logic {
        S_IDLE,
        S_DRAIN
    } state_t;

    state_t                 state_reg, state_next;
    logic                   m_valid_reg, m_valid_next;
    status_t                status_reg, status_next;
    logic [CW-1:0]          count_reg, count_next;
    logic [CW-1:0]          drain_reg, drain_next;
    logic                   from_tk_reg, from_tk_next;

    logic [CW:0]   cnt_inc;
    logic [CW-1:0] cnt_dec;
    logic          is_ins, is_rem;
    logic          full, empty;
    status_t       op_status;
    logic          accept;

    assign cnt_inc = {1'b0, count_reg} + 1'b1;
    assign cnt_dec = count_reg - 1'b1;
    assign full    = (count_reg == CW'(CAPACITY));
    assign empty   = (count_reg == '0);

    always_comb begin
        is_ins  = 1'b0;
        is_rem  = 1'b0;
        pos_eff = position;
        case (op_t'(operation))
            OP_PUSH_BACK: begin
                is_ins  = 1'b1;
                pos_eff = count_reg;
            end
            OP_POP_BACK: begin
                is_rem  = 1'b1;
                pos_eff = cnt_dec;
            end
            OP_INSERT_AT: begin
                is_ins = 1'b1;
            end
            OP_REMOVE_AT: begin
                is_rem = 1'b1;
            end
            OP_INSERT_MIDDLE: begin
                is_ins  = 1'b1;
                pos_eff = cnt_inc[CW:1];
            end
            OP_REMOVE_MIDDLE: begin
                is_rem  = 1'b1;
                pos_eff = cnt_dec >> 1;
            end
            default: begin
                pos_eff = position;
            end
        endcase
    end

    always_comb begin
        op_status = ST_OK;
        if (is_ins) begin
            if (full) begin
                op_status = ST_FULL;
            end else if (pos_eff > count_reg) begin
                op_status = ST_BADIDX;
            end
        end else if (is_rem) begin
            if (empty) begin
                op_status = ST_EMPTY;
            end else if (pos_eff >= count_reg) begin
                op_status = ST_BADIDX;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        cell_ctrl.ins = accept && is_ins && (op_status == ST_OK);
        cell_ctrl.rem = accept && is_rem && (op_status == ST_OK);
        cell_ctrl.cap = accept && is_rem && (op_status == ST_OK);
        cell_ctrl.shf = (state_reg == S_DRAIN) && (drain_reg != '0);
    end

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        status_next  = status_reg;
        count_next   = count_reg;
        drain_next   = drain_reg;
        from_tk_next = from_tk_reg;
        case (state_reg)
            S_IDLE: begin
                if (m_valid_reg && m_tready) begin
                    m_valid_next = 1'b0;
                end
                if (accept) begin
                    status_next  = op_status;
                    from_tk_next = 1'b0;
                    if (cell_ctrl.rem) begin
                        state_next   = S_DRAIN;
                        m_valid_next = 1'b0;
                        drain_next   = pos_eff;
                        count_next   = cnt_dec;
                    end else begin
                        m_valid_next = 1'b1;
                        if (cell_ctrl.ins) begin
                            count_next = cnt_inc[CW-1:0];
                        end
                    end
                end
            end
            S_DRAIN: begin
                if (drain_reg != '0) begin
                    drain_next = drain_reg - 1'b1;
                end else begin
                    m_valid_next = 1'b1;
                    from_tk_next = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            status_reg  <= ST_OK;
            count_reg   <= '0;
            drain_reg   <= '0;
            from_tk_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            status_reg  <= status_next;
            count_reg   <= count_next;
            drain_reg   <= drain_next;
            from_tk_reg <= from_tk_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign status   = status_reg;
    assign count    = count_reg;
    assign from_tk  = from_tk_reg;

endmodule

[tb/testbench.sv]
// self-checking testbench for the indexed insert/remove list
`timescale 1ns / 1ps

module testbench
    import iira_pkg::*;
();

    localparam int CAPACITY = 16;
    localparam int CW       = 5;
    localparam int S_W      = 40;
    localparam int M_W      = 40;
    localparam int PHASE_ITEMS = 270;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [OP_BITS-1:0] OP_UNKNOWN_6 = 3'd6;
    localparam logic [OP_BITS-1:0] OP_UNKNOWN_7 = 3'd7;

    localparam op_t GROW_OPS [3]   = '{OP_PUSH_BACK, OP_INSERT_AT, OP_INSERT_MIDDLE};
    localparam op_t SHRINK_OPS [3] = '{OP_POP_BACK, OP_REMOVE_AT, OP_REMOVE_MIDDLE};

    localparam int SEND_IDLE [5] = '{0, 79, 0, 24, 0};
    localparam int RECV_STALL [5] = '{0, 0, 79, 24, 10};

    typedef struct packed {
        status_t           status;
        logic [31:0]       taken_word;
        logic [CW-1:0]     element_count;
    } list_result_t;

    typedef struct {
        logic [OP_BITS-1:0] op;
        logic [CW-1:0]      pos;
        logic [31:0]        word;
        int                 reps;
        bit                 typed;
        status_t            status;
        logic [31:0]        taken_word;
        logic [CW-1:0]      element_count;
    } list_row_t;

    logic           aclk = 1'b0;
    logic           aresetn = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    logic [S_W-1:0] s_tdata = '0;  // operation, position, data_word
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    logic [M_W-1:0] m_tdata;       // status, taken_word, element_count

    logic [31:0]    shadow_words [CAPACITY];
    int             shadow_count = 0;
    list_result_t   pending_results [$];
    int             error_count = 0;
    int             send_idle_pct = 0;
    int             stall_pct = 0;
    int             hold_trigger = 0;
    int             hold_taken = 0;
    int             hold_left = 0;

    list_row_t directed_rows [23] = '{
        '{OP_POP_BACK,      5'd0,  32'h0000_0000, 1,  1'b1, ST_EMPTY,  32'h0, 5'd0},
        '{OP_REMOVE_AT,     5'd31, 32'h0000_0000, 1,  1'b1, ST_EMPTY,  32'h0, 5'd0},
        '{OP_REMOVE_MIDDLE, 5'd0,  32'h0000_0000, 1,  1'b1, ST_EMPTY,  32'h0, 5'd0},
        '{OP_INSERT_AT,     5'd1,  32'hDEAD_BEEF, 1,  1'b1, ST_BADIDX, 32'h0, 5'd0},
        '{OP_UNKNOWN_7,     5'd31, 32'hFFFF_FFFF, 1,  1'b1, ST_OK,     32'h0, 5'd0},
        '{OP_PUSH_BACK,     5'd0,  32'hFFFF_FFFF, 1,  1'b1, ST_OK,     32'h0, 5'd1},
        '{OP_INSERT_AT,     5'd1,  32'h0000_0000, 1,  1'b1, ST_OK,     32'h0, 5'd2},
        '{OP_INSERT_AT,     5'd0,  32'hA5A5_A5A5, 1,  1'b0, ST_OK,     32'h0, 5'd0},
        '{OP_INSERT_MIDDLE, 5'd0,  32'h5A5A_5A5A, 1,  1'b0, ST_OK,     32'h0, 5'd0},
        '{OP_REMOVE_AT,     5'd4,  32'h0000_0000, 1,  1'b1, ST_BADIDX, 32'h0, 5'd4},
        '{OP_UNKNOWN_6,     5'd16, 32'hFFFF_FFFF, 1,  1'b1, ST_OK,     32'h0, 5'd4},
        '{OP_REMOVE_MIDDLE, 5'd0,  32'h0000_0000, 1,  1'b0, ST_OK,     32'h0, 5'd0},
        '{OP_POP_BACK,      5'd0,  32'h0000_0000, 1,  1'b0, ST_OK,     32'h0, 5'd0},
        '{OP_REMOVE_AT,     5'd0,  32'h0000_0000, 1,  1'b0, ST_OK,     32'h0, 5'd0},
        '{OP_PUSH_BACK,     5'd0,  32'h8000_0001, 15, 1'b0, ST_OK,     32'h0, 5'd0},
        '{OP_PUSH_BACK,     5'd0,  32'h1234_5678, 1,  1'b1, ST_FULL,   32'h0, 5'd16},
        '{OP_INSERT_AT,     5'd31, 32'h1234_5678, 1,  1'b1, ST_FULL,   32'h0, 5'd16},
        '{OP_INSERT_MIDDLE, 5'd0,  32'h1234_5678, 1,  1'b1, ST_FULL,   32'h0, 5'd16},
        '{OP_REMOVE_AT,     5'd15, 32'h0000_0000, 1,  1'b0, ST_OK,     32'h0, 5'd0},
        '{OP_REMOVE_AT,     5'd15, 32'h0000_0000, 1,  1'b1, ST_BADIDX, 32'h0, 5'd15},
        '{OP_INSERT_AT,     5'd15, 32'h0F0F_0F0F, 1,  1'b0, ST_OK,     32'h0, 5'd0},
        '{OP_REMOVE_MIDDLE, 5'd0,  32'h0000_0000, 1,  1'b0, ST_OK,     32'h0, 5'd0},
        '{OP_POP_BACK,      5'd0,  32'h0000_0000, 15, 1'b0, ST_OK,     32'h0, 5'd0}
    };

    indexed_insert_remove_array i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic status_t list_insert(int at, logic [31:0] word);
        if (shadow_count >= CAPACITY) begin
            return ST_FULL;
        end
        if (at > shadow_count) begin
            return ST_BADIDX;
        end
        for (int i = shadow_count; i > at; i--) begin
            shadow_words[i] = shadow_words[i-1];
        end
        shadow_words[at] = word;
        shadow_count++;
        return ST_OK;
    endfunction

    function automatic status_t list_remove(int at, output logic [31:0] taken);
        taken = '0;
        if (shadow_count == 0) begin
            return ST_EMPTY;
        end
        if (at >= shadow_count) begin
            return ST_BADIDX;
        end
        taken = shadow_words[at];
        for (int i = at; i + 1 < shadow_count; i++) begin
            shadow_words[i] = shadow_words[i+1];
        end
        shadow_count--;
        return ST_OK;
    endfunction

    function automatic list_result_t apply_list_op(logic [OP_BITS-1:0] op, logic [CW-1:0] pos,
                                                   logic [31:0] word);
        list_result_t res;
        logic [31:0]  taken;
        res.status = ST_OK;
        taken = '0;
        case (op)
            OP_PUSH_BACK:     res.status = list_insert(shadow_count, word);
            OP_POP_BACK:      res.status = list_remove(shadow_count - 1, taken);
            OP_INSERT_AT:     res.status = list_insert(int'(pos), word);
            OP_REMOVE_AT:     res.status = list_remove(int'(pos), taken);
            OP_INSERT_MIDDLE: res.status = list_insert((shadow_count + 1) / 2, word);
            OP_REMOVE_MIDDLE: res.status = list_remove((shadow_count - 1) / 2, taken);
            default: ;
        endcase
        res.taken_word    = taken;
        res.element_count = CW'(shadow_count);
        return res;
    endfunction

    task automatic send_list_op(logic [OP_BITS-1:0] op, logic [CW-1:0] pos, logic [31:0] word,
                                bit typed, list_result_t typed_result);
        list_result_t predicted;
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {word, pos, op};
        do @(posedge aclk); while (!s_tready);
        predicted = apply_list_op(op, pos, word);
        pending_results.push_back(typed ? typed_result : predicted);
    endtask

    task automatic send_random_op(int grow_pct);
        logic [OP_BITS-1:0] op;
        logic [CW-1:0]      pos;
        logic [31:0]        word;
        bit                 grows;
        grows = 1'b0;
        if ($urandom_range(99) < 3) begin
            op = $urandom_range(1) ? OP_UNKNOWN_6 : OP_UNKNOWN_7;
        end else if ($urandom_range(99) < grow_pct) begin
            op = GROW_OPS[$urandom_range(2)];
            grows = 1'b1;
        end else begin
            op = SHRINK_OPS[$urandom_range(2)];
        end
        if ($urandom_range(99) < 12) begin
            pos = CW'($urandom_range(31));
        end else if (grows) begin
            pos = CW'($urandom_range(shadow_count));
        end else begin
            pos = CW'($urandom_range(shadow_count == 0 ? 0 : shadow_count - 1));
        end
        case ($urandom_range(9))
            0:       word = '0;
            1:       word = '1;
            default: word = $urandom;
        endcase
        send_list_op(op, pos, word, 1'b0, '0);
    endtask

    // receiver side: random stalls plus a long hold-off on request
    always @(posedge aclk) begin
        if (hold_trigger != hold_taken) begin
            hold_taken <= hold_trigger;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin : result_check
        list_result_t want;
        status_t      got_status;
        logic [31:0]  got_taken;
        logic [CW-1:0] got_count;
        if (aresetn && m_tvalid && m_tready) begin
            got_status = status_t'(m_tdata[1:0]);
            got_taken  = m_tdata[33:2];
            got_count  = m_tdata[38:34];
            if (pending_results.size() == 0) begin
                $error("result item with nothing expected: status %0d taken %h count %0d",
                       got_status, got_taken, got_count);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (got_status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, got_status);
                    error_count++;
                end
                if (got_taken != want.taken_word) begin
                    $error("taken_word: expected %h, got %h", want.taken_word, got_taken);
                    error_count++;
                end
                if (got_count != want.element_count) begin
                    $error("element_count: expected %0d, got %0d",
                           want.element_count, got_count);
                    error_count++;
                end
            end
        end
    end

    initial begin
        list_result_t typed_result;
        int           grow_pct;
        for (int i = 0; i < CAPACITY; i++) begin
            shadow_words[i] = '0;
        end
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[r]) begin
            typed_result.status        = directed_rows[r].status;
            typed_result.taken_word    = directed_rows[r].taken_word;
            typed_result.element_count = directed_rows[r].element_count;
            for (int k = 0; k < directed_rows[r].reps; k++) begin
                send_list_op(directed_rows[r].op, directed_rows[r].pos,
                             directed_rows[r].word + 32'(k), directed_rows[r].typed,
                             typed_result);
            end
        end

        grow_pct = 50;
        for (int phase = 0; phase < 5; phase++) begin
            send_idle_pct = SEND_IDLE[phase];
            stall_pct     <= RECV_STALL[phase];
            if (phase == 4) begin
                hold_trigger <= hold_trigger + 1;
            end
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // alternate runs that fill, drain or churn the list
                if (n % 40 == 0) begin
                    case ($urandom_range(2))
                        0:       grow_pct = 80;
                        1:       grow_pct = 20;
                        default: grow_pct = 50;
                    endcase
                end
                send_random_op(grow_pct);
            end
        end
        s_tvalid <= 1'b0;

        while (pending_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0) begin
            $display("indexed_insert_remove_array test passed");
        end else begin
            $display("indexed_insert_remove_array test failed");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("indexed_insert_remove_array test failed");
        $finish;
    end

endmodule
